>>> rtl/gsir_pkg.sv
// ----------------------------------------------------------------------------
// gsir_pkg
// Shared types and constants of the interrupt GSI route resolver: request and
// response beats, table entry layouts, action and status codes.
// ----------------------------------------------------------------------------
package gsir_pkg;

	localparam int CTL_DEPTH = 8;
	localparam int CTL_AW = (CTL_DEPTH > 1) ? $clog2(CTL_DEPTH) : 1;
	localparam int CTL_CW = $clog2(CTL_DEPTH + 1);

	localparam int ISA_LINES = 16;
	localparam int OVR_AW = $clog2(ISA_LINES);

	localparam logic [15:0] LEGACY_LIMIT = 16'd16;
	localparam logic [7:0] REDIR_FIRST = 8'h10;
	localparam logic [31:0] RTE_LOW_BIT = 32'h0000_2000;
	localparam logic [31:0] RTE_LEVEL_BIT = 32'h0000_8000;
	localparam logic [31:0] RTE_MASK_BIT = 32'h0001_0000;
	localparam logic [1:0] FLAG_ACTIVE = 2'b11;

	typedef enum logic [2:0] {
		ACT_CLEAR   = 3'd0,
		ACT_ADD_CTL = 3'd1,
		ACT_ADD_OVR = 3'd2,
		ACT_PROGRAM = 3'd3,
		ACT_MASK    = 3'd4,
		ACT_UNMASK  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_CTL  = 2'd1,
		ST_FULL    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] gsi;
		logic [7:0]  max_entry;
		logic [7:0]  source_irq;
		logic [7:0]  bus;
		logic [3:0]  flags;
		logic [7:0]  vector;
		logic [7:0]  dest_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  controller;
		logic [7:0]  pin;
		logic [7:0]  redir_reg;
		logic [31:0] rte_low;
		logic [31:0] rte_high;
		logic        level;
		logic        polarity_low;
		logic        mask_value;
	} rsp_t;

	typedef struct packed {
		logic [15:0] base;
		logic [8:0]  inputs;
	} ctl_entry_t;

	typedef struct packed {
		logic        low;
		logic        level;
		logic [15:0] target;
	} ovr_entry_t;

	// Engine to output stage.
	typedef struct packed {
		logic done;
		rsp_t rsp;
	} eng_out_t;

endpackage

>>> rtl/gsir_ram.sv
// ----------------------------------------------------------------------------
// gsir_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gsir_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 8,
	parameter int ADDR_W = 3
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/gsir_engine.sv
// ----------------------------------------------------------------------------
// gsir_engine
// Request sequencer: updates the controller and override tables and walks
// them one entry per cycle to resolve a GSI into controller, pin and entry.
// ----------------------------------------------------------------------------
module gsir_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  gsir_pkg::req_t      req,
	input  logic                out_free,
	output gsir_pkg::eng_out_t  eng
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CWALK,
		S_OWALK,
		S_FINISH
	} state_t;

	state_t                       state_q;
	gsir_pkg::req_t               req_q;
	gsir_pkg::status_t            status_q;
	logic [gsir_pkg::CTL_CW-1:0]  count_q;
	logic [gsir_pkg::ISA_LINES-1:0] ovr_valid_q;
	logic [gsir_pkg::CTL_AW-1:0]  cidx_q;
	logic [gsir_pkg::OVR_AW-1:0]  oidx_q;
	logic [gsir_pkg::CTL_AW-1:0]  ctl_q;
	logic [7:0]                   pin_q;
	logic                         low_q;
	logic                         lvl_q;

	logic                         accept;
	logic                         ctl_we;
	logic                         ovr_we;
	logic                         ctl_room;
	logic                         ovr_ok;
	logic [gsir_pkg::CTL_AW-1:0]  ctl_raddr;
	logic [gsir_pkg::OVR_AW-1:0]  ovr_raddr;
	gsir_pkg::ctl_entry_t         ctl_wdata;
	gsir_pkg::ctl_entry_t         ctl_rd;
	gsir_pkg::ovr_entry_t         ovr_wdata;
	gsir_pkg::ovr_entry_t         ovr_rd;
	logic [16:0]                  diff;
	logic                         ctl_hit;
	logic                         cwalk_last;
	logic                         ovr_hit;
	logic                         flag_low;
	logic                         flag_lvl;
	logic [31:0]                  rte_low;

	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;

	assign ctl_room = (count_q < gsir_pkg::CTL_CW'(gsir_pkg::CTL_DEPTH));
	assign ovr_ok = (req.bus == 8'd0) &&
		(req.source_irq < 8'(gsir_pkg::ISA_LINES));
	assign flag_low = (req.flags[1:0] == gsir_pkg::FLAG_ACTIVE);
	assign flag_lvl = (req.flags[3:2] == gsir_pkg::FLAG_ACTIVE);

	assign ctl_we = accept && (req.action == gsir_pkg::ACT_ADD_CTL) && ctl_room;
	assign ovr_we = accept && (req.action == gsir_pkg::ACT_ADD_OVR) && ovr_ok;

	assign ctl_wdata.base = req.gsi;
	assign ctl_wdata.inputs = 9'(req.max_entry) + 9'd1;
	assign ovr_wdata.low = flag_low;
	assign ovr_wdata.level = flag_lvl;
	assign ovr_wdata.target = req.gsi;

	// Read addresses run one entry ahead of the walk index, so the entry under
	// test is always the registered read data.
	assign ctl_raddr = (state_q == S_CWALK) ?
		cidx_q + gsir_pkg::CTL_AW'(1) : '0;
	assign ovr_raddr = (state_q == S_OWALK) ?
		oidx_q + gsir_pkg::OVR_AW'(1) : '0;

	gsir_ram #(
		.DEPTH  (gsir_pkg::CTL_DEPTH),
		.WIDTH  ($bits(gsir_pkg::ctl_entry_t)),
		.ADDR_W (gsir_pkg::CTL_AW)
	) u_ctl_ram (
		.clk   (clk),
		.we    (ctl_we),
		.waddr (gsir_pkg::CTL_AW'(count_q)),
		.wdata (ctl_wdata),
		.raddr (ctl_raddr),
		.rdata (ctl_rd)
	);

	gsir_ram #(
		.DEPTH  (gsir_pkg::ISA_LINES),
		.WIDTH  ($bits(gsir_pkg::ovr_entry_t)),
		.ADDR_W (gsir_pkg::OVR_AW)
	) u_ovr_ram (
		.clk   (clk),
		.we    (ovr_we),
		.waddr (req.source_irq[gsir_pkg::OVR_AW-1:0]),
		.wdata (ovr_wdata),
		.raddr (ovr_raddr),
		.rdata (ovr_rd)
	);

	assign diff = {1'b0, req_q.gsi} - {1'b0, ctl_rd.base};
	assign ctl_hit = !diff[16] && (diff < {8'd0, ctl_rd.inputs});
	assign cwalk_last = (gsir_pkg::CTL_CW'(cidx_q) + gsir_pkg::CTL_CW'(1) == count_q);
	assign ovr_hit = ovr_valid_q[oidx_q] && (ovr_rd.target == req_q.gsi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			status_q <= gsir_pkg::ST_OK;
			count_q <= '0;
			ovr_valid_q <= '0;
			cidx_q <= '0;
			oidx_q <= '0;
			ctl_q <= '0;
			pin_q <= '0;
			low_q <= 1'b0;
			lvl_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= req;
						status_q <= gsir_pkg::ST_OK;
						cidx_q <= '0;
						oidx_q <= '0;
						ctl_q <= '0;
						pin_q <= '0;
						low_q <= 1'b0;
						lvl_q <= 1'b0;
						state_q <= S_FINISH;
						case (req.action)
							gsir_pkg::ACT_CLEAR: begin
								count_q <= '0;
								ovr_valid_q <= '0;
							end
							gsir_pkg::ACT_ADD_CTL: begin
								if (ctl_room) begin
									ctl_q <= gsir_pkg::CTL_AW'(count_q);
									count_q <= count_q + gsir_pkg::CTL_CW'(1);
								end else begin
									status_q <= gsir_pkg::ST_FULL;
								end
							end
							gsir_pkg::ACT_ADD_OVR: begin
								if (ovr_ok) begin
									ovr_valid_q[req.source_irq[gsir_pkg::OVR_AW-1:0]] <= 1'b1;
									low_q <= flag_low;
									lvl_q <= flag_lvl;
								end else begin
									status_q <= gsir_pkg::ST_IGNORED;
								end
							end
							gsir_pkg::ACT_PROGRAM, gsir_pkg::ACT_MASK,
							gsir_pkg::ACT_UNMASK: begin
								if (count_q == '0) begin
									status_q <= gsir_pkg::ST_NO_CTL;
								end else begin
									state_q <= S_CWALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CWALK: begin
					if (ctl_hit) begin
						ctl_q <= cidx_q;
						pin_q <= diff[7:0];
						if (req_q.action == gsir_pkg::ACT_PROGRAM) begin
							low_q <= (req_q.gsi >= gsir_pkg::LEGACY_LIMIT);
							lvl_q <= (req_q.gsi >= gsir_pkg::LEGACY_LIMIT);
							state_q <= S_OWALK;
						end else begin
							state_q <= S_FINISH;
						end
					end else if (cwalk_last) begin
						status_q <= gsir_pkg::ST_NO_CTL;
						state_q <= S_FINISH;
					end else begin
						cidx_q <= cidx_q + gsir_pkg::CTL_AW'(1);
					end
				end
				S_OWALK: begin
					// Later matching overrides replace earlier ones.
					if (ovr_hit) begin
						low_q <= ovr_rd.low;
						lvl_q <= ovr_rd.level;
					end
					if (oidx_q == gsir_pkg::OVR_AW'(gsir_pkg::ISA_LINES - 1)) begin
						state_q <= S_FINISH;
					end else begin
						oidx_q <= oidx_q + gsir_pkg::OVR_AW'(1);
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rte_low = 32'(req_q.vector) | gsir_pkg::RTE_MASK_BIT |
		(low_q ? gsir_pkg::RTE_LOW_BIT : 32'd0) |
		(lvl_q ? gsir_pkg::RTE_LEVEL_BIT : 32'd0);

	always_comb begin
		eng = '0;
		eng.done = (state_q == S_FINISH);
		eng.rsp.status = status_q;
		if (status_q == gsir_pkg::ST_OK) begin
			case (req_q.action)
				gsir_pkg::ACT_ADD_CTL: begin
					eng.rsp.controller = 3'(ctl_q);
				end
				gsir_pkg::ACT_ADD_OVR: begin
					eng.rsp.level = lvl_q;
					eng.rsp.polarity_low = low_q;
				end
				gsir_pkg::ACT_PROGRAM: begin
					eng.rsp.controller = 3'(ctl_q);
					eng.rsp.pin = pin_q;
					eng.rsp.redir_reg = gsir_pkg::REDIR_FIRST + {pin_q[6:0], 1'b0};
					eng.rsp.rte_low = rte_low;
					eng.rsp.rte_high = {req_q.dest_id, 24'd0};
					eng.rsp.level = lvl_q;
					eng.rsp.polarity_low = low_q;
					eng.rsp.mask_value = 1'b1;
				end
				gsir_pkg::ACT_MASK, gsir_pkg::ACT_UNMASK: begin
					eng.rsp.controller = 3'(ctl_q);
					eng.rsp.pin = pin_q;
					eng.rsp.redir_reg = gsir_pkg::REDIR_FIRST + {pin_q[6:0], 1'b0};
					eng.rsp.mask_value = (req_q.action == gsir_pkg::ACT_MASK);
				end
				default: begin
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gsir_pkg::CTL_CW'(gsir_pkg::CTL_DEPTH))
		else $error("controller count beyond table depth");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CWALK) |-> (gsir_pkg::CTL_CW'(cidx_q) < count_q))
		else $error("controller walk past the filled entries");

	a_clear_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.action == gsir_pkg::ACT_CLEAR) |=>
		(count_q == '0 && ovr_valid_q == '0))
		else $error("clear left table state behind");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(eng.done && status_q == gsir_pkg::ST_FULL) |->
		(count_q == gsir_pkg::CTL_CW'(gsir_pkg::CTL_DEPTH)))
		else $error("table full reported with free entries");

endmodule

>>> rtl/interrupt_gsi_route_resolver.sv
// ----------------------------------------------------------------------------
// interrupt_gsi_route_resolver
// Resolves a GSI to its interrupt controller, pin and redirection entry, and
// maintains the controller and ISA source override tables.
// ----------------------------------------------------------------------------
// Clear, add controller, add override and unused actions go from idle straight
// to the result beat; mask, unmask and a program that finds no controller first
// read the controller entries, up to 8 of them, and a program that hits then also
// reads all 16 override entries. The engine returns to idle as the result loads
// and takes no new request before that. Reset empties both tables.
module interrupt_gsi_route_resolver (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  gsir_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output gsir_pkg::rsp_t  rsp
);

	gsir_pkg::eng_out_t eng;
	gsir_pkg::rsp_t     rsp_q;
	logic               rsp_valid_q;
	logic               out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	gsir_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.out_free  (out_free),
		.eng       (eng)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (eng.done && out_free) begin
				rsp_valid_q <= 1'b1;
				rsp_q <= eng.rsp;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
